// ----- src/sfce_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfce_pkg: shared types and constants
// Field widths, fixed-point constants and the front-to-back queue entry.
// ----------------------------------------------------------------------------
package sfce_pkg;
    localparam int MAX_CHANNELS = 8;
    localparam int ENERGY_WIDTH = 48;
    localparam logic [15:0] Q_ATTACK  = 16'd42598;
    localparam logic [15:0] Q_RELEASE = 16'd6554;
    localparam logic [15:0] Q_CENTER  = 16'd22938;
    localparam logic [15:0] Q_MONO    = 16'd42598;
    localparam logic [15:0] Q_NEUTRAL = 16'd32768;
    localparam logic [5:0]  BOX_MAX   = 6'd63;
    localparam logic [1:0]  REG_CHANNELS = 2'd0;
    localparam logic [1:0]  REG_IN_RATE  = 2'd1;
    localparam logic [1:0]  REG_DET_RATE = 2'd2;
    localparam logic [1:0]  REG_FRAME    = 2'd3;

    typedef struct packed {
        logic               verdict;
        logic               speech;
        logic signed [15:0] mono;
        logic signed [17:0] side;
        logic               stereo;
    } t_entry;
endpackage

// ----- src/sfce_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfce_front: input stage
// Accepts items, forms the downmix and side value, and queues an entry.
// The mean over other channel counts uses a serial restoring divider.
// ----------------------------------------------------------------------------
module sfce_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic [3:0]           i_channels,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic                 i_command,
    input  logic                 i_speech,
    input  logic [127:0]         i_chans,
    output logic                 o_valid,
    input  logic                 i_ready,
    output sfce_pkg::t_entry     o_entry
);
    sfce_pkg::t_entry r_q [2];
    logic [1:0] r_cnt;
    logic r_wp, r_rp;
    logic r_busy;
    logic [4:0] r_step;
    logic [18:0] r_num, r_rem;
    logic [3:0] r_div;
    logic r_neg;
    logic [15:0] r_quo;
    logic [18:0] n_sum;
    logic [18:0] n_abs;
    logic [3:0] n_n;
    logic signed [16:0] n_l, n_r, n_ms, n_ss;
    logic signed [16:0] n_mh, n_sh;
    logic [19:0] n_trial;
    logic push, pop;
    sfce_pkg::t_entry n_e;

    assign n_n = (i_channels > 4'd8) ? 4'd8 : i_channels;
    always_comb begin
        n_sum = '0;
        for (int c = 0; c < sfce_pkg::MAX_CHANNELS; c++) begin
            if (c < n_n) begin
                n_sum = n_sum + {{3{i_chans[16*c+15]}}, i_chans[16*c +: 16]};
            end
        end
        n_abs = n_sum[18] ? (~n_sum + 19'd1) : n_sum;
        n_l = {i_chans[15], i_chans[15:0]};
        n_r = {i_chans[31], i_chans[31:16]};
        n_ms = n_l + n_r;
        n_ss = n_l - n_r;
        n_mh = (n_ms[16] ? (n_ms + 17'sd1) : n_ms) >>> 1;
        n_sh = (n_ss[16] ? (n_ss + 17'sd1) : n_ss) >>> 1;
        n_trial = {r_rem[18:0], r_num[18]} - {16'd0, r_div};
    end

    assign o_ready = !r_busy && (r_cnt != 2'd2);
    wire acc = i_valid && o_ready;

    always_comb begin
        n_e.verdict = i_command;
        n_e.speech = i_speech;
        n_e.stereo = (n_n == 4'd2);
        n_e.mono = n_mh[15:0];
        n_e.side = {{2{n_sh[16]}}, n_sh[15:0]};
        if (r_busy) begin
            n_e.verdict = 1'b0;
            n_e.speech = 1'b0;
            n_e.stereo = 1'b0;
            n_e.mono = r_neg ? (~r_quo + 16'd1) : r_quo;
            n_e.side = '0;
        end
    end

    wire direct = acc && (i_command || n_n == 4'd2 || n_n == 4'd1);
    wire done = r_busy && (r_step == 5'd19);
    assign push = direct || done;
    assign pop = o_valid && i_ready;
    assign o_valid = (r_cnt != 2'd0);
    assign o_entry = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_wp <= 1'b0;
            r_rp <= 1'b0;
            r_busy <= 1'b0;
            r_step <= '0;
        end else begin
            if (push) begin
                r_q[r_wp] <= (n_n == 4'd1 && !i_command && !r_busy) ?
                    '{verdict: 1'b0, speech: 1'b0, mono: i_chans[15:0],
                      side: '0, stereo: 1'b0} : n_e;
                r_wp <= ~r_wp;
            end
            if (pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, pop};
            if (acc && !direct && n_n != 4'd0) begin
                r_busy <= 1'b1;
                r_step <= '0;
                r_num <= n_abs;
                r_rem <= '0;
                r_div <= n_n;
                r_neg <= n_sum[18];
                r_quo <= '0;
            end else if (r_busy) begin
                if (done) begin
                    r_busy <= 1'b0;
                end else begin
                    r_step <= r_step + 5'd1;
                    r_num <= {r_num[17:0], 1'b0};
                    if (!n_trial[19]) begin
                        r_rem <= n_trial[18:0];
                        r_quo <= {r_quo[14:0], 1'b1};
                    end else begin
                        r_rem <= {r_rem[17:0], r_num[18]};
                        r_quo <= {r_quo[14:0], 1'b0};
                    end
                end
            end
        end
    end

    a_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n) r_cnt != 2'd3)
        else $error("queue count overflow");
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n) r_busy |-> !o_ready)
        else $error("accept while dividing");
    a_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd2) |-> !push)
        else $error("push into full queue");
endmodule

// ----- src/sfce_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfce_back: resampler and estimator
// Box-average resampling, frame counting, energy tracking and smoothing.
// Divisions are done by two serial units, box and ratio; multiplies are registered.
// ----------------------------------------------------------------------------
module sfce_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic [3:0]         i_channels,
    input  logic [17:0]        i_in_rate,
    input  logic [15:0]        i_det_rate,
    input  logic [8:0]         i_frame_len,
    input  logic               i_valid,
    output logic               o_ready,
    input  sfce_pkg::t_entry   i_entry,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [49:0]        o_data
);
    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001, S_SQ = 7'b0000010, S_BOX = 7'b0000100,
        S_BDIV = 7'b0001000, S_EMIT = 7'b0010000, S_CDIV = 7'b0100000,
        S_OUT = 7'b1000000
    } t_state;
    localparam int EW = sfce_pkg::ENERGY_WIDTH;
    localparam logic [EW-1:0] EMAX = {EW{1'b1}};

    t_state r_st;
    sfce_pkg::t_entry r_e;
    logic [17:0] r_phase;
    logic signed [23:0] r_box;
    logic [5:0] r_bcnt;
    logic [8:0] r_fidx;
    logic [EW-1:0] r_mid, r_side;
    logic [15:0] r_sp, r_cd;
    logic [33:0] r_msq, r_ssq;
    logic [4:0] r_k;
    logic [23:0] r_dn;
    logic [23:0] r_dq;
    logic [5:0] r_dr;
    logic r_dneg;
    logic [EW:0] r_rr, r_tot;
    logic [15:0] r_cq;
    logic [16:0] r_tgt;
    logic r_fend;
    logic signed [15:0] r_samp;
    logic r_full;

    function automatic logic [15:0] smooth(input logic [15:0] x, input logic [16:0] t,
                                           input logic [15:0] c);
        logic [16:0] a;
        logic [33:0] p;
        logic [17:0] d;
        a = (t >= {1'b0, x}) ? (t - {1'b0, x}) : ({1'b0, x} - t);
        p = c * a + 34'd32768;
        d = {1'b0, p[32:16]};
        if (t >= {1'b0, x}) begin
            d = d + {2'b0, x};
            return (d > 18'd65535) ? 16'hFFFF : d[15:0];
        end
        return (d >= {2'b0, x}) ? 16'd0 : (x - d[15:0]);
    endfunction

    wire [EW:0] n_sumE = {1'b0, r_mid} + {1'b0, r_side};
    wire [EW:0] n_twice = {r_rr[EW-1:0], 1'b0};
    wire [6:0] n_dtr = {r_dr, r_dn[23]} - {1'b0, r_bcnt};
    wire [18:0] n_ph = {1'b0, r_phase} + {3'b0, i_det_rate};
    wire n_eq = ({2'b0, i_det_rate} == i_in_rate);
    wire [EW:0] n_mx = (r_msq > {14'd0, EMAX[EW-1:0]} - r_mid) ? {1'b0, EMAX} :
                       {1'b0, r_mid} + {{(EW-33){1'b0}}, r_msq};
    wire [EW:0] n_sx = (r_ssq > {14'd0, EMAX[EW-1:0]} - r_side) ? {1'b0, EMAX} :
                       {1'b0, r_side} + {{(EW-33){1'b0}}, r_ssq};
    wire [23:0] n_qv = r_dneg ? (~r_dq + 24'd1) : r_dq;
    wire signed [23:0] n_qs = n_qv;

    assign o_ready = (r_st == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE;
            r_phase <= '0;
            r_box <= '0;
            r_bcnt <= '0;
            r_fidx <= '0;
            r_mid <= '0;
            r_side <= '0;
            r_sp <= '0;
            r_cd <= sfce_pkg::Q_NEUTRAL;
            r_full <= 1'b0;
        end else begin
            if (o_valid && i_ready && r_st != S_OUT) r_full <= 1'b0;
            case (r_st)
                S_IDLE: begin
                    if (i_valid) begin
                        r_e <= i_entry;
                        if (i_entry.verdict) begin
                            r_sp <= smooth(r_sp, i_entry.speech ? 17'h10000 : 17'd0,
                                ((i_entry.speech ? 17'h10000 : 17'd0) > {1'b0, r_sp})
                                ? sfce_pkg::Q_ATTACK : sfce_pkg::Q_RELEASE);
                            r_samp <= '0;
                            r_fend <= 1'b0;
                            r_st <= S_OUT;
                        end else begin
                            r_msq <= 34'($signed(i_entry.mono) * $signed(i_entry.mono));
                            r_ssq <= 34'($signed(i_entry.side) * $signed(i_entry.side));
                            r_st <= S_SQ;
                        end
                    end
                end
                S_SQ: begin
                    if (r_e.stereo) begin
                        r_mid <= n_mx[EW-1:0];
                        r_side <= n_sx[EW-1:0];
                    end
                    if (n_eq) begin
                        r_samp <= r_e.mono;
                        r_st <= S_EMIT;
                    end else begin
                        if (r_bcnt < sfce_pkg::BOX_MAX) begin
                            r_box <= r_box + 24'(r_e.mono);
                            r_bcnt <= r_bcnt + 6'd1;
                        end
                        r_st <= S_BOX;
                    end
                end
                S_BOX: begin
                    if (n_ph < {1'b0, i_in_rate}) begin
                        r_phase <= n_ph[17:0];
                        r_st <= S_IDLE;
                    end else begin
                        r_phase <= ((n_ph - {1'b0, i_in_rate}) >= {1'b0, i_in_rate}) ? 18'd0
                                   : 18'(n_ph - {1'b0, i_in_rate});
                        r_dneg <= r_box[23];
                        r_dn <= r_box[23] ? (~r_box + 24'd1) : r_box;
                        r_dr <= '0;
                        r_dq <= '0;
                        r_k <= '0;
                        r_st <= S_BDIV;
                    end
                end
                S_BDIV: begin
                    r_dn <= {r_dn[22:0], 1'b0};
                    if (!n_dtr[6]) begin
                        r_dr <= n_dtr[5:0];
                        r_dq <= {r_dq[22:0], 1'b1};
                    end else begin
                        r_dr <= {r_dr[4:0], r_dn[23]};
                        r_dq <= {r_dq[22:0], 1'b0};
                    end
                    r_k <= r_k + 5'd1;
                    if (r_k == 5'd23) r_st <= S_EMIT;
                end
                S_EMIT: begin
                    if (!n_eq) begin
                        r_samp <= (n_qs > 24'sd32767) ? 16'sh7FFF :
                                  (n_qs < -24'sd32768) ? 16'sh8000 : n_qs[15:0];
                        r_box <= '0;
                        r_bcnt <= '0;
                    end
                    if ({1'b0, r_fidx} + 10'd1 >= {1'b0, i_frame_len}) begin
                        r_fidx <= '0;
                        r_fend <= 1'b1;
                        r_k <= '0;
                        r_cq <= '0;
                        r_rr <= n_sumE[EW] ? {1'b0, r_mid} : {1'b0, r_mid};
                        r_tot <= n_sumE;
                        r_st <= S_CDIV;
                    end else begin
                        r_fidx <= r_fidx + 9'd1;
                        r_fend <= 1'b0;
                        r_st <= S_OUT;
                    end
                end
                S_CDIV: begin
                    if (r_k < 5'd16) begin
                        if (r_rr >= r_tot - r_rr) begin
                            r_rr <= r_rr - (r_tot - r_rr);
                            r_cq <= {r_cq[14:0], 1'b1};
                        end else begin
                            r_rr <= n_twice;
                            r_cq <= {r_cq[14:0], 1'b0};
                        end
                        r_k <= r_k + 5'd1;
                    end else begin
                        r_cd <= smooth(r_cd,
                            (i_channels == 4'd1) ? {1'b0, sfce_pkg::Q_MONO} :
                            (i_channels != 4'd2) ? {1'b0, sfce_pkg::Q_NEUTRAL} :
                            (r_tot == '0) ? {1'b0, sfce_pkg::Q_NEUTRAL} :
                            (r_side == '0) ? 17'h10000 : {1'b0, r_cq},
                            sfce_pkg::Q_CENTER);
                        r_mid <= '0;
                        r_side <= '0;
                        r_st <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (!r_full || i_ready) begin
                        r_full <= 1'b1;
                        o_data <= {r_sp, r_cd, r_fend, !r_e.verdict, r_samp};
                        r_st <= S_IDLE;
                    end
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end
    assign o_valid = r_full;

    a_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == S_OUT && !r_full) |=> r_full)
        else $error("result not registered");
    a_box: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == S_BDIV) |-> (r_bcnt != 6'd0))
        else $error("box division by zero count");
    a_fidx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_st == S_CDIV) |-> (r_fidx == 9'd0))
        else $error("frame index not cleared");
endmodule

// ----- src/speech_frontend_center_estimator_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// speech_frontend_center_estimator_top: speech front-end center estimator
// Downmix, resampling to detector rate, center dominance and speech smoothing.
// ----------------------------------------------------------------------------
// A sample item whose rates are equal passes the square, emit and output states
// before it is registered as a result; one that forms a resampled sample also
// passes the box state and the 24-step serial box divider, and one that forms no
// sample frees the back end after the box state. A frame end adds the 16-step
// ratio divider, and a mean over other than one or two channels adds the front
// divider. Verdict items go from idle straight to the output state.
module speech_frontend_center_estimator_top (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_we,
    input  logic [1:0]   i_cfg_idx,
    input  logic [17:0]  i_cfg_data,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // tdata: chan0..chan7
    input  logic [127:0] s_axis_tdata,
    // tuser: command, speech_flag
    input  logic [1:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // tdata: detector_sample, center_dominance, speech_probability
    output logic [47:0]  m_axis_tdata,
    // tuser: sample_valid
    output logic         m_axis_tuser,
    output logic         m_axis_tlast
);
    logic [3:0] r_ch;
    logic [17:0] r_in;
    logic [15:0] r_det;
    logic [8:0] r_fl;
    logic qv, qr;
    sfce_pkg::t_entry qe;
    logic [49:0] res_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ch <= 4'd2;
            r_in <= 18'd48000;
            r_det <= 16'd16000;
            r_fl <= 9'd160;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                sfce_pkg::REG_CHANNELS: r_ch <= i_cfg_data[3:0];
                sfce_pkg::REG_IN_RATE:  r_in <= i_cfg_data;
                sfce_pkg::REG_DET_RATE: r_det <= i_cfg_data[15:0];
                sfce_pkg::REG_FRAME:    r_fl <= i_cfg_data[8:0];
                default: ;
            endcase
        end
    end

    sfce_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_channels(r_ch),
        .i_valid(s_axis_tvalid && !(r_ch == 4'd0 && !s_axis_tuser[0])),
        .o_ready(s_axis_tready), .i_command(s_axis_tuser[0]),
        .i_speech(s_axis_tuser[1]), .i_chans(s_axis_tdata),
        .o_valid(qv), .i_ready(qr), .o_entry(qe)
    );

    sfce_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_channels(r_ch), .i_in_rate(r_in),
        .i_det_rate(r_det), .i_frame_len(r_fl),
        .i_valid(qv), .o_ready(qr), .i_entry(qe),
        .o_valid(m_axis_tvalid), .i_ready(m_axis_tready), .o_data(res_data)
    );

    assign m_axis_tdata = {res_data[49:18], res_data[15:0]};
    assign m_axis_tuser = res_data[16];
    assign m_axis_tlast = res_data[17];
endmodule
